// ===== hdl/ebfc_pkg.sv =====
// ----------------------------------------------------------------------------
// ebfc_pkg
// Shared types and constants for the display-data block fetch checker.
// ----------------------------------------------------------------------------
package ebfc_pkg;

  localparam int unsigned BLOCK_BYTES_DEFAULT = 128;

  localparam logic [6:0]  DEVICE_ADDRESS_RESET = 7'd80;
  localparam logic [15:0] RETRY_TICKS_RESET    = 16'd5000;
  localparam logic [7:0]  READ_OFFSET          = 8'h00;
  localparam logic [7:0]  SIGNATURE_BYTE       = 8'hFF;
  localparam logic [7:0]  SUM_GOOD             = 8'h00;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ENABLE         = 2'd0,
    CFG_DEVICE_ADDRESS = 2'd1,
    CFG_RETRY_TICKS    = 2'd2,
    CFG_UNUSED         = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_READ  = 2'd1,
    PH_CHECK = 2'd2,
    PH_WAIT  = 2'd3
  } phase_t;

  typedef struct packed {
    logic       cmd_space;
    logic       rx_ready;
    logic [7:0] rx_byte;
    logic       tick;
  } in_t;

  typedef struct packed {
    logic       set_target;
    logic [6:0] target_address;
    logic       cmd_push;
    logic       cmd_read;
    logic       cmd_stop;
    logic [7:0] cmd_data;
    logic       byte_taken;
    logic [6:0] byte_index;
    logic [7:0] byte_value;
    logic       block_valid;
    logic [1:0] phase;
  } out_t;

  typedef struct packed {
    logic        enable;
    logic [6:0]  device_address;
    logic [15:0] retry_ticks;
  } cfg_t;

endpackage

// ===== hdl/ebfc_core.sv =====
// ----------------------------------------------------------------------------
// ebfc_core
// Fetch loop state and the single-pass step logic that turns one poll step
// into one result and the next state.
// ----------------------------------------------------------------------------
module ebfc_core #(
  parameter int unsigned BLOCK_BYTES = ebfc_pkg::BLOCK_BYTES_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  ebfc_pkg::in_t  item,
  input  ebfc_pkg::cfg_t cfg,
  output ebfc_pkg::out_t result
);
  import ebfc_pkg::*;

  localparam int unsigned CW = $clog2(BLOCK_BYTES + 1);
  localparam logic [CW-1:0] LAST_COUNT = CW'(BLOCK_BYTES - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(BLOCK_BYTES);
  localparam logic [CW-1:0] ONE_COUNT  = CW'(1);

  phase_t        phase_reg, phase_next;
  logic [CW-1:0] issued_count, issued_count_next;
  logic [CW-1:0] received_count, received_count_next;
  logic [7:0]    byte_sum, byte_sum_next;
  logic [7:0]    second_byte, second_byte_next;
  logic [15:0]   wait_count, wait_count_next;
  logic          valid_flag, valid_flag_next;

  always_comb begin
    phase_next = phase_reg;
    if (cfg.enable) begin
      unique case (phase_reg)
        PH_START: begin
          if (item.cmd_space) begin
            phase_next = PH_READ;
          end
        end
        PH_READ: begin
          if ((received_count >= FULL_COUNT) ||
              (item.rx_ready && (received_count == LAST_COUNT))) begin
            phase_next = PH_CHECK;
          end
        end
        PH_CHECK: phase_next = PH_WAIT;
        PH_WAIT: begin
          if (wait_count == 16'd0) begin
            phase_next = PH_START;
          end
        end
        default: phase_next = PH_START;
      endcase
    end
  end

  always_comb begin
    result              = '0;
    issued_count_next   = issued_count;
    received_count_next = received_count;
    byte_sum_next       = byte_sum;
    second_byte_next    = second_byte;
    wait_count_next     = wait_count;
    valid_flag_next     = valid_flag;
    if (cfg.enable) begin
      unique case (phase_reg)
        PH_START: begin
          result.set_target     = 1'b1;
          result.target_address = cfg.device_address;
          if (item.cmd_space) begin
            result.cmd_push     = 1'b1;
            result.cmd_stop     = 1'b1;
            result.cmd_data     = READ_OFFSET;
            issued_count_next   = '0;
            received_count_next = '0;
            byte_sum_next       = '0;
            second_byte_next    = '0;
          end
        end
        PH_READ: begin
          if (item.cmd_space && (issued_count < FULL_COUNT)) begin
            result.cmd_push   = 1'b1;
            result.cmd_read   = 1'b1;
            result.cmd_stop   = (issued_count == LAST_COUNT);
            issued_count_next = issued_count + ONE_COUNT;
          end
          if (item.rx_ready && (received_count < FULL_COUNT)) begin
            result.byte_taken   = 1'b1;
            result.byte_index   = 7'(received_count);
            result.byte_value   = item.rx_byte;
            byte_sum_next       = byte_sum + item.rx_byte;
            received_count_next = received_count + ONE_COUNT;
            if (received_count == ONE_COUNT) begin
              second_byte_next = item.rx_byte;
            end
          end
        end
        PH_CHECK: begin
          valid_flag_next = (byte_sum == SUM_GOOD) && (second_byte == SIGNATURE_BYTE);
          wait_count_next = cfg.retry_ticks;
        end
        PH_WAIT: begin
          if ((wait_count != 16'd0) && item.tick) begin
            wait_count_next = wait_count - 16'd1;
          end
        end
        default: begin
          valid_flag_next = valid_flag;
        end
      endcase
    end
    result.block_valid = valid_flag_next;
    result.phase       = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg      <= PH_START;
      issued_count   <= '0;
      received_count <= '0;
      byte_sum       <= '0;
      second_byte    <= '0;
      wait_count     <= '0;
      valid_flag     <= 1'b0;
    end else if (step) begin
      phase_reg      <= phase_next;
      issued_count   <= issued_count_next;
      received_count <= received_count_next;
      byte_sum       <= byte_sum_next;
      second_byte    <= second_byte_next;
      wait_count     <= wait_count_next;
      valid_flag     <= valid_flag_next;
    end
  end

  a_write_only_from_start: assert property (@(posedge clk) disable iff (rst)
    (result.cmd_push && !result.cmd_read) |-> (phase_reg == PH_START))
    else $error("write entry pushed outside the start phase");

  a_take_only_reading: assert property (@(posedge clk) disable iff (rst)
    result.byte_taken |-> (phase_reg == PH_READ && cfg.enable))
    else $error("byte taken outside the reading phase");

  a_check_to_wait: assert property (@(posedge clk) disable iff (rst)
    (step && cfg.enable && phase_reg == PH_CHECK) |=> (phase_reg == PH_WAIT))
    else $error("check step did not enter the waiting phase");

  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    (received_count <= FULL_COUNT) && (issued_count <= FULL_COUNT))
    else $error("block counters ran past the block length");

  a_frozen_when_disabled: assert property (@(posedge clk) disable iff (rst)
    (step && !cfg.enable) |=> $stable(phase_reg) && $stable(valid_flag))
    else $error("state changed while disabled");

endmodule

// ===== hdl/edid_block_fetch_checker_unit.sv =====
// ----------------------------------------------------------------------------
// edid_block_fetch_checker_unit
// Polls an I2C master's FIFOs to fetch one display-data block, checks it, and
// repeats after a programmable number of timer ticks.
// ----------------------------------------------------------------------------
// Path: an accepted poll step waits in the input register, and combinational
// step logic between the two registers writes its result to the result register.
// Throughput: one poll step per cycle unless out_stall holds the output full.
// Reset: rst is synchronous; it empties both registers, returns to the start
// phase, clears the counters and the valid flag, and loads register defaults.
module edid_block_fetch_checker_unit #(
  parameter int unsigned BLOCK_BYTES = ebfc_pkg::BLOCK_BYTES_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ebfc_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ebfc_pkg::out_t                      out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ebfc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ebfc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ebfc_pkg::*;

  cfg_t cfg;
  in_t  in_item;
  logic in_full;
  out_t out_item;
  logic out_full;
  out_t step_result;
  logic advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable         <= 1'b0;
      cfg.device_address <= DEVICE_ADDRESS_RESET;
      cfg.retry_ticks    <= RETRY_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_ENABLE:         cfg.enable         <= cfg_data[0];
        CFG_DEVICE_ADDRESS: cfg.device_address <= cfg_data[6:0];
        CFG_RETRY_TICKS:    cfg.retry_ticks    <= cfg_data;
        default:            cfg.enable         <= cfg.enable;
      endcase
    end
  end

  assign advance  = in_full && (!out_full || !out_stall);
  assign in_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item <= in_data;
    end
  end

  ebfc_core #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .step  (advance),
    .item  (in_item),
    .cfg   (cfg),
    .result(step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance) begin
      out_full <= 1'b1;
    end else if (!out_stall) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= step_result;
    end
  end

  assign out_valid = out_full;
  assign out_data  = out_item;

endmodule
